@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, codes and constants of the reply frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

  // Frame layout
  localparam int unsigned POS_W         = 5;
  localparam logic [POS_W-1:0] POS_FIRST    = 5'd0;
  localparam logic [POS_W-1:0] POS_HEAD2    = 5'd1;
  localparam logic [POS_W-1:0] POS_TYPE     = 5'd2;
  localparam logic [POS_W-1:0] POS_PAY_LO   = 5'd3;
  localparam logic [POS_W-1:0] POS_PAY_HI   = 5'd8;
  localparam logic [POS_W-1:0] POS_MODE     = 5'd9;
  localparam logic [POS_W-1:0] POS_STATUS   = 5'd16;
  localparam logic [POS_W-1:0] POS_CHECKSUM = 5'd17;
  localparam logic [POS_W-1:0] POS_TAIL1    = 5'd18;
  localparam logic [POS_W-1:0] POS_LAST     = 5'd19;

  localparam int unsigned PAY_N       = 6;
  localparam logic [7:0]  RECV_MODE_CODE = 8'd12;

  // Verdict queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 56;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HEAD_FIRST    = 3'd0,
    REG_HEAD_SECOND   = 3'd1,
    REG_TAIL_FIRST    = 3'd2,
    REG_TAIL_SECOND   = 3'd3,
    REG_CODE_LINK     = 3'd4,
    REG_CODE_INIT     = 3'd5,
    REG_CODE_POWER    = 3'd6,
    REG_CODE_CHANNEL  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_HEAD     = 3'd1,
    ERR_TAIL     = 3'd2,
    ERR_TYPE     = 3'd3,
    ERR_CHECKSUM = 3'd4,
    ERR_STATUS   = 3'd5
  } err_code_t;

  typedef enum logic [1:0] {
    KIND_LINK    = 2'd0,
    KIND_INIT    = 2'd1,
    KIND_POWER   = 2'd2,
    KIND_CHANNEL = 2'd3
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] head_first;
    logic [7:0] head_second;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
    logic [7:0] code_link;
    logic [7:0] code_init;
    logic [7:0] code_power;
    logic [7:0] code_channel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    head_first:   8'h55,
    head_second:  8'haa,
    tail_first:   8'hff,
    tail_second:  8'hff,
    code_link:    8'd1,
    code_init:    8'd2,
    code_power:   8'd3,
    code_channel: 8'd4
  };

  // One finished frame, as handed from front to back
  typedef struct packed {
    logic                     head_ok;
    logic                     tail_ok;
    logic                     check_ok;
    logic [7:0]               type_byte;
    logic [PAY_N-1:0][7:0]    payload;     // payload[0] is frame byte 3
    logic [7:0]               status_byte; // frame byte 16
    logic                     mode_hit;    // frame byte 9 was the receive code
  } frame_rec_t;

endpackage

@@ rtl/rfc_front.sv @@
// ----------------------------------------------------------------------------
// rfc_front
// Byte tracker: frame position, running XOR and capture of frame fields.
// ----------------------------------------------------------------------------
module rfc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_take,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  input  rfc_pkg::cfg_t         cfg,
  output logic                  rec_push,
  output rfc_pkg::frame_rec_t   rec
);
  import rfc_pkg::*;

  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_eff;
  logic [POS_W-1:0]      pos_next;
  logic [7:0]            xor_acc;
  logic                  head_ok;
  logic                  tail_ok;
  logic                  check_ok;
  logic [7:0]            type_byte;
  logic [PAY_N-1:0][7:0] payload;
  logic [7:0]            status_byte;
  logic                  mode_hit;
  logic [POS_W-1:0]      pay_off;

  // Start flag forces byte 0; a stray position also restarts
  always_comb begin
    if (frame_start || (pos > POS_LAST)) begin
      pos_eff = POS_FIRST;
    end else begin
      pos_eff = pos;
    end
    pos_next = (pos_eff == POS_LAST) ? POS_FIRST : pos_eff + 5'd1;
    pay_off  = pos_eff - POS_PAY_LO;
  end

  // Position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_FIRST;
    end else if (in_take) begin
      pos <= pos_next;
    end
  end

  // Field capture and checksum
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (pos_eff == POS_FIRST) begin
        xor_acc <= rx_byte;
        head_ok <= (rx_byte == cfg.head_first);
      end else if (pos_eff <= POS_STATUS) begin
        xor_acc <= xor_acc ^ rx_byte;
      end
      if (pos_eff == POS_HEAD2) begin
        head_ok <= head_ok && (rx_byte == cfg.head_second);
      end
      if (pos_eff == POS_TYPE) begin
        type_byte <= rx_byte;
      end
      if ((pos_eff >= POS_PAY_LO) && (pos_eff <= POS_PAY_HI)) begin
        payload[pay_off[2:0]] <= rx_byte;
      end
      if (pos_eff == POS_MODE) begin
        mode_hit <= (rx_byte == RECV_MODE_CODE);
      end
      if (pos_eff == POS_STATUS) begin
        status_byte <= rx_byte;
      end
      if (pos_eff == POS_CHECKSUM) begin
        check_ok <= (xor_acc == rx_byte);
      end
      if (pos_eff == POS_TAIL1) begin
        tail_ok <= (rx_byte == cfg.tail_first);
      end
    end
  end

  // Last byte closes the frame and hands a record to the back end
  assign rec_push = in_take && (pos_eff == POS_LAST);

  always_comb begin
    rec.head_ok     = head_ok;
    rec.tail_ok     = tail_ok && (rx_byte == cfg.tail_second);
    rec.check_ok    = check_ok;
    rec.type_byte   = type_byte;
    rec.payload     = payload;
    rec.status_byte = status_byte;
    rec.mode_hit    = mode_hit;
  end

endmodule

@@ rtl/rfc_queue.sv @@
// ----------------------------------------------------------------------------
// rfc_queue
// Short FIFO of finished frame records between front and back.
// ----------------------------------------------------------------------------
module rfc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rfc_pkg::frame_rec_t   rec_in,
  output logic                  full,
  input  logic                  pop,
  output logic                  rec_valid,
  output rfc_pkg::frame_rec_t   rec_out
);
  import rfc_pkg::*;

  frame_rec_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic                    do_push;
  logic                    do_pop;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  assign full      = (count == CNT_FULL);
  assign rec_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && rec_valid;
  assign rec_out   = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= rec_in;
    end
  end

endmodule

@@ rtl/rfc_back.sv @@
// ----------------------------------------------------------------------------
// rfc_back
// Verdict stage: type decode, ordered checks and the output register.
// ----------------------------------------------------------------------------
module rfc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rfc_pkg::cfg_t               cfg,
  input  logic                        rec_valid,
  input  rfc_pkg::frame_rec_t         rec,
  output logic                        rec_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rfc_pkg::OUT_DATA_W-1:0] out_data
);
  import rfc_pkg::*;

  frame_kind_t kind;
  err_code_t   err;
  logic        known;
  logic        chan;
  logic [7:0]  status;
  logic        out_free;
  logic [OUT_DATA_W-1:0] verdict;

  // Type decode, first match wins
  always_comb begin
    known  = 1'b1;
    kind   = KIND_LINK;
    status = 8'd0;
    priority if (rec.type_byte == cfg.code_link) begin
      kind = KIND_LINK;
    end else if (rec.type_byte == cfg.code_init) begin
      kind   = KIND_INIT;
      status = rec.payload[1];
    end else if (rec.type_byte == cfg.code_power) begin
      kind   = KIND_POWER;
      status = rec.payload[0];
    end else if (rec.type_byte == cfg.code_channel) begin
      kind   = KIND_CHANNEL;
      status = rec.status_byte;
    end else begin
      known = 1'b0;
    end
  end

  // Ordered checks
  always_comb begin
    chan = 1'b0;
    priority if (!rec.head_ok) begin
      err = ERR_HEAD;
    end else if (!rec.tail_ok) begin
      err = ERR_TAIL;
    end else if (!known) begin
      err = ERR_TYPE;
    end else begin
      chan = (kind == KIND_CHANNEL);
      if (!rec.check_ok) begin
        err = ERR_CHECKSUM;
      end else if (status != 8'd0) begin
        err = ERR_STATUS;
      end else begin
        err = ERR_OK;
      end
    end
  end

  // Pack the result word
  always_comb begin
    verdict        = '0;
    verdict[0]     = (err == ERR_OK);
    verdict[3:1]   = err;
    verdict[5:4]   = kind;
    if (chan) begin
      verdict[53:6] = rec.payload;
      verdict[54]   = rec.mode_hit;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign rec_pop  = rec_valid && out_free;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_data <= verdict;
    end
  end

endmodule

@@ rtl/reply_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// reply_frame_checker_top
// Checks 20-byte antenna-module reply frames and gives one verdict per frame.
// ----------------------------------------------------------------------------
// Input stream: one frame byte per word; tuser marks byte 0 of a new frame.
// Bytes are taken at one per cycle while s_axis_tready is high. Without a start
// flag the position simply counts on and wraps after byte 19; a start flag mid-frame
// drops the partial frame. The first byte after reset counts as byte 0.
// Output stream: one verdict word per complete frame; the edge that takes byte
// 19 writes the verdict queue, and the output register is loaded from the queue
// once it is free. Verdicts leave at one per cycle while m_axis_tready is high.
// A two-entry verdict queue sits between the byte tracker and the output
// register, so a stalled receiver does not stop byte intake; s_axis_tready
// falls only once two verdicts wait behind a held output word.
// Configuration: cfg_we writes cfg_data into register cfg_addr;
// write only while no frame is in flight.
// Reset returns all configuration registers to their defaults, the position to byte 0,
// and empties the queue and the output register.
// ----------------------------------------------------------------------------
module reply_frame_checker_top (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [rfc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // byte stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rfc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
  input  logic                              s_axis_tuser,  // [0] frame_start
  // verdict stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] accepted, [3:1] error_code, [5:4] frame_kind, [13:6] chan_row,
  // [21:14] chan_col, [29:22] send_magn, [37:30] send_phase,
  // [45:38] recv_magn, [53:46] recv_phase, [54] recv_mode, [55] zero
  output logic [rfc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import rfc_pkg::*;

  cfg_t       cfg;
  logic       in_take;
  logic       q_full;
  logic       rec_push;
  frame_rec_t rec_front;
  logic       rec_valid;
  frame_rec_t rec_back;
  logic       rec_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_HEAD_FIRST:   cfg.head_first   <= cfg_data;
        REG_HEAD_SECOND:  cfg.head_second  <= cfg_data;
        REG_TAIL_FIRST:   cfg.tail_first   <= cfg_data;
        REG_TAIL_SECOND:  cfg.tail_second  <= cfg_data;
        REG_CODE_LINK:    cfg.code_link    <= cfg_data;
        REG_CODE_INIT:    cfg.code_init    <= cfg_data;
        REG_CODE_POWER:   cfg.code_power   <= cfg_data;
        REG_CODE_CHANNEL: cfg.code_channel <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  rfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_take     (in_take),
    .rx_byte     (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .cfg         (cfg),
    .rec_push    (rec_push),
    .rec         (rec_front)
  );

  rfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .rec_in    (rec_front),
    .full      (q_full),
    .pop       (rec_pop),
    .rec_valid (rec_valid),
    .rec_out   (rec_back)
  );

  rfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec       (rec_back),
    .rec_pop   (rec_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

@@ rtl/rfc_checker.sv @@
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level assertions on the verdict stream of the reply frame checker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [rfc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import rfc_pkg::*;

  // held word stays up and unchanged
  `AST_NEXT(a_hold_valid, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped while stalled")
  `AST_NEXT(a_hold_data, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "word changed while stalled")

  // accepted flag agrees with the error code
  `AST_IMPLY(a_acc_err, clk, rst, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[3:1] == ERR_OK), "accepted flag disagrees with error code")

  // error code stays in its defined range
  `AST_IMPLY(a_err_range, clk, rst, m_axis_tvalid, m_axis_tdata[3:1] <= ERR_STATUS, "error code out of range")

  // channel fields only for channel control frames past head and tail
  `AST_IMPLY(a_chan_zero, clk, rst, m_axis_tvalid && ((m_axis_tdata[5:4] != KIND_CHANNEL) || (m_axis_tdata[3:1] == ERR_HEAD) || (m_axis_tdata[3:1] == ERR_TAIL)), m_axis_tdata[55:6] == 50'd0, "channel fields set for a non-channel verdict")

endmodule

bind reply_frame_checker_top rfc_checker u_rfc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
